[src/wrra_pkg.sv]
// Shared constants and codes for the windowed regression residual AR(1) unit.
package wrra_pkg;

  localparam int MAX_WINDOW_DEF = 4096;
  localparam int PRICE_W        = 24;
  localparam int WIN_W          = 13;
  localparam int STATUS_W       = 2;
  localparam int RHO_W          = 32;
  localparam int RES_W          = 48;
  localparam int WIN_MIN        = 3;
  localparam int HIST_EXTRA     = 3;

  localparam logic [WIN_W-1:0] WIN_RESET = 13'd200;

  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FLAT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_VALID = 2'd2;

  // register index is paddr[2]
  localparam logic REG_WINDOW = 1'b0;

  localparam logic [5:0] BETA_FB  = 6'd40;
  localparam logic [5:0] ALPHA_FB = 6'd0;
  localparam logic [5:0] RHO_FB   = 6'd29;

  localparam logic [63:0] LIM48   = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] LIM_RHO = 64'h0000_0000_7FFF_FFFF;

endpackage

[src/wrra_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wrra_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/window_regression_residual_ar1_unit.sv]
// Top level: bar ring memory, two window passes, shared multiplier and divider.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------------
//   in       | in_valid / in_ready   | in_open_price, in_close_price (24 b)
//   out      | out_valid / out_ready | out_status (2 b), out_rho (Q2.29)
//   config   | APB psel/penable      | window_length at paddr 0
//
// An item with too little history goes from idle straight to the push state. A full
// fit makes two streaming passes over the ring RAM (one bar per cycle), nine
// multiplies, and up to three bit-serial divisions (beta, alpha, rho).
// in_ready is high only between items; a finished result waits in the output
// register while the next request is taken. Reset is synchronous; the ring
// needs no clearing pass since only written entries are ever read.
module window_regression_residual_ar1_unit
  import wrra_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [PRICE_W-1:0]         in_open_price,
  input  logic [PRICE_W-1:0]         in_close_price,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [RHO_W-1:0]    out_rho,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int WW = AW + 1;
  localparam int BW = $clog2(MAX_WINDOW + 4);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;
  localparam logic [3:0] S_DEN0  = 4'd2;
  localparam logic [3:0] S_DEN1  = 4'd3;
  localparam logic [3:0] S_NUM0  = 4'd4;
  localparam logic [3:0] S_NUM1  = 4'd5;
  localparam logic [3:0] S_BETA  = 4'd6;
  localparam logic [3:0] S_AN    = 4'd7;
  localparam logic [3:0] S_ALPHA = 4'd8;
  localparam logic [3:0] S_RES   = 4'd9;
  localparam logic [3:0] S_DD0   = 4'd10;
  localparam logic [3:0] S_DD1   = 4'd11;
  localparam logic [3:0] S_NN0   = 4'd12;
  localparam logic [3:0] S_NN1   = 4'd13;
  localparam logic [3:0] S_RHO   = 4'd14;
  localparam logic [3:0] S_PUSH  = 4'd15;

  localparam logic signed [51:0] U_HI = 52'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [51:0] U_LO = -52'sh0_8000_0000_0000;

  logic [3:0]          state_r, state_nxt;
  logic [AW-1:0]       wp_r;
  logic [BW-1:0]       bars_r;
  logic [WIN_W-1:0]    win_r;
  logic [WW-1:0]       weff, weff_r;
  logic [AW-1:0]       base_r, addr_r, start_addr, pass_base;
  logic [WW-1:0]       iss_r;
  logic                in_acc, enough, issuing, pass_go, pass_done;
  logic [AW-1:0]       wp_inc;
  logic [BW-1:0]       bars_inc;
  logic [WW:0]         st_a, st_b;

  // ring RAM
  logic [2*PRICE_W-1:0] rd_data;
  logic [PRICE_W-1:0]   rd_open, rd_close;

  // pass pipeline
  logic                 v1_r, v2_r, v3_r, v4_r, f1_r, f2_r, f3_r;
  logic [PRICE_W-1:0]   x2_r, y2_r, op_a, op_b;
  logic [2*PRICE_W-1:0] m0_r, m1_r;
  logic [63:0]          sx_r, sy_r, sxx_r, sxy_r;
  logic signed [63:0]   su_r, sv_r;
  logic [127:0]         suu_r, suv_r;
  logic signed [RES_W-1:0] u3_r, prev_r, u_sat;
  logic signed [72:0]   aa_lo_r, ba_lo_r;
  logic signed [71:0]   aa_hi_r, ba_hi_r;
  logic [48:0]          t_rnd, t_mag;
  logic signed [51:0]   t_s, cl_s, al_s, u_raw;
  logic [127:0]         aa_ext, ba_ext;

  // fit results
  logic signed [RES_W-1:0] alpha_r;
  logic [RES_W-1:0]     beta_mag_r;
  logic                 beta_neg_r;
  logic [127:0]         t0_r, den_r, dd_r, diff;
  logic                 t0_ld, den_ld, dd_ld, beta_ld, alpha_ld, res_ld, push_go;
  logic [STATUS_W-1:0]  res_st_in, res_st_r;
  logic [RHO_W-1:0]     res_rho_in, res_rho_r;

  // shared multiplier: 128-bit times signed 64-bit, one byte a cycle
  logic [127:0]         mul_a_r, mul_acc_r, mul_pp, mul_a_in;
  logic [63:0]          mul_b_r, mul_b_in;
  logic                 mul_neg_r, mul_ld, mul_done;
  logic [3:0]           mul_cnt_r;

  // shared divider: restoring, one quotient bit a cycle
  logic                 div_ld, dv_run_r, dv_neg_r, dl_neg;
  logic [127:0]         div_n_in, div_d_in, dv_r_r, dv_n_r, dv_d_r, dl_mag;
  logic [5:0]           div_fb_in;
  logic [63:0]          div_lim_in, dl_max, dv_max_r, dv_int_r, dv_q_r;
  logic [7:0]           dv_cnt_r, dv_last_r;
  logic signed [63:0]   dv_res_r;
  logic [127:0]         dv_r2, dv_rnew;
  logic                 dv_ge, dv_ovf_r, dv_ovfnew;
  logic [63:0]          dv_qnew, dv_rnd, dv_mag;
  logic                 dv_fin;

  // output register
  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_r;
  logic [RHO_W-1:0]     out_rho_r;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_WINDOW) ? {{(32-WIN_W){1'b0}}, win_r} : 32'd0;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign out_valid  = out_valid_q;
  assign out_status = out_status_r;
  assign out_rho    = $signed(out_rho_r);

  always_comb begin
    if (win_r < WIN_W'(WIN_MIN)) begin
      weff = WW'(WIN_MIN);
    end else if (32'(win_r) > MAX_WINDOW) begin
      weff = WW'(MAX_WINDOW);
    end else begin
      weff = WW'(win_r);
    end
  end

  assign wp_inc   = (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + 1'b1;
  assign bars_inc = (bars_r == BW'(MAX_WINDOW + 3)) ? bars_r : bars_r + 1'b1;
  assign enough   = 32'(bars_inc) >= 32'(weff) + 32'(HIST_EXTRA);
  assign st_a       = {2'b0, wp_inc} - {1'b0, weff};
  assign st_b       = {2'b0, wp_inc} + (WW+1)'(MAX_WINDOW) - {1'b0, weff};
  assign start_addr = ({1'b0, wp_inc} >= weff) ? st_a[AW-1:0] : st_b[AW-1:0];
  assign pass_base  = (state_r == S_IDLE) ? start_addr : base_r;

  wrra_ram #(
    .WIDTH (2*PRICE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp_r),
    .wdata ({in_open_price, in_close_price}),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  assign rd_open  = rd_data[2*PRICE_W-1:PRICE_W];
  assign rd_close = rd_data[PRICE_W-1:0];

  assign issuing   = ((state_r == S_SUM) || (state_r == S_RES)) && (iss_r != weff_r);
  assign pass_done = (iss_r == weff_r) && !v1_r && !v2_r && !v3_r && !v4_r;

  // first pass forms open*open and open*close; second pass scales open by |beta| in two halves
  assign op_a = (state_r == S_SUM) ? rd_open  : beta_mag_r[PRICE_W-1:0];
  assign op_b = (state_r == S_SUM) ? rd_close : beta_mag_r[RES_W-1:PRICE_W];

  // residual: close<<16 - alpha - round(beta*open / 2^24)
  assign t_rnd = ({1'b0, m0_r} + 49'h0_0000_0080_0000) >> 24;
  assign t_mag = {1'b0, m1_r} + t_rnd;
  assign t_s   = beta_neg_r ? -$signed({3'b0, t_mag}) : $signed({3'b0, t_mag});
  assign cl_s  = $signed({12'b0, y2_r, 16'b0});
  assign al_s  = $signed({{4{alpha_r[RES_W-1]}}, alpha_r});
  assign u_raw = cl_s - al_s - t_s;

  always_comb begin
    if (u_raw > U_HI) begin
      u_sat = 48'sh7FFF_FFFF_FFFF;
    end else if (u_raw < U_LO) begin
      u_sat = -48'sh8000_0000_0000;
    end else begin
      u_sat = u_raw[RES_W-1:0];
    end
  end

  assign aa_ext = ({{56{aa_hi_r[71]}}, aa_hi_r} << 24) + {{55{aa_lo_r[72]}}, aa_lo_r};
  assign ba_ext = ({{56{ba_hi_r[71]}}, ba_hi_r} << 24) + {{55{ba_lo_r[72]}}, ba_lo_r};

  assign mul_pp   = mul_a_r * mul_b_r[7:0];
  assign mul_done = (mul_cnt_r == 4'd9);
  assign diff     = t0_r - mul_acc_r;

  assign dl_neg = div_n_in[127];
  assign dl_mag = dl_neg ? -div_n_in : div_n_in;
  assign dl_max = dl_neg ? div_lim_in + 64'd1 : div_lim_in;

  assign dv_r2     = {dv_r_r[126:0], dv_n_r[127]};
  assign dv_ge     = dv_r2 >= dv_d_r;
  assign dv_rnew   = dv_ge ? dv_r2 - dv_d_r : dv_r2;
  assign dv_qnew   = {dv_q_r[62:0], dv_ge};
  assign dv_ovfnew = dv_ovf_r | dv_q_r[63];
  assign dv_rnd    = (dv_qnew + 64'd1) >> 1;

  always_comb begin
    dv_fin = 1'b0;
    dv_mag = dv_max_r;
    if (dv_cnt_r == 8'd127 && (dv_ovfnew || dv_qnew > dv_int_r)) begin
      dv_fin = 1'b1;
    end else if (dv_cnt_r == dv_last_r) begin
      dv_fin = 1'b1;
      dv_mag = (dv_rnd > dv_max_r) ? dv_max_r : dv_rnd;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    mul_ld     = 1'b0;
    mul_a_in   = '0;
    mul_b_in   = '0;
    div_ld     = 1'b0;
    div_n_in   = '0;
    div_d_in   = '0;
    div_fb_in  = '0;
    div_lim_in = LIM48;
    t0_ld      = 1'b0;
    den_ld     = 1'b0;
    dd_ld      = 1'b0;
    beta_ld    = 1'b0;
    alpha_ld   = 1'b0;
    res_ld     = 1'b0;
    res_st_in  = ST_SHORT;
    res_rho_in = '0;
    pass_go    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (enough) begin
            pass_go   = 1'b1;
            state_nxt = S_SUM;
          end else begin
            res_ld    = 1'b1;
            state_nxt = S_PUSH;
          end
        end
      end
      S_SUM: begin
        if (pass_done) begin
          mul_ld    = 1'b1;
          mul_a_in  = {64'd0, sxx_r};
          mul_b_in  = 64'(weff_r);
          state_nxt = S_DEN0;
        end
      end
      S_DEN0: begin
        if (mul_done) begin
          t0_ld     = 1'b1;
          mul_ld    = 1'b1;
          mul_a_in  = {64'd0, sx_r};
          mul_b_in  = sx_r;
          state_nxt = S_DEN1;
        end
      end
      S_DEN1: begin
        if (mul_done) begin
          if (diff == 128'd0) begin
            res_ld    = 1'b1;
            res_st_in = ST_FLAT;
            state_nxt = S_PUSH;
          end else begin
            den_ld    = 1'b1;
            mul_ld    = 1'b1;
            mul_a_in  = {64'd0, sxy_r};
            mul_b_in  = 64'(weff_r);
            state_nxt = S_NUM0;
          end
        end
      end
      S_NUM0: begin
        if (mul_done) begin
          t0_ld     = 1'b1;
          mul_ld    = 1'b1;
          mul_a_in  = {64'd0, sy_r};
          mul_b_in  = sx_r;
          state_nxt = S_NUM1;
        end
      end
      S_NUM1: begin
        if (mul_done) begin
          div_ld    = 1'b1;
          div_n_in  = diff;
          div_d_in  = den_r;
          div_fb_in = BETA_FB;
          state_nxt = S_BETA;
        end
      end
      S_BETA: begin
        if (!dv_run_r) begin
          beta_ld   = 1'b1;
          mul_ld    = 1'b1;
          mul_a_in  = {{64{dv_res_r[63]}}, dv_res_r};
          mul_b_in  = sx_r;
          state_nxt = S_AN;
        end
      end
      S_AN: begin
        if (mul_done) begin
          div_ld    = 1'b1;
          div_n_in  = (128'(sy_r) << 40) - mul_acc_r;
          div_d_in  = 128'(weff_r) << 24;
          div_fb_in = ALPHA_FB;
          state_nxt = S_ALPHA;
        end
      end
      S_ALPHA: begin
        if (!dv_run_r) begin
          alpha_ld  = 1'b1;
          pass_go   = 1'b1;
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (pass_done) begin
          mul_ld    = 1'b1;
          mul_a_in  = suu_r;
          mul_b_in  = 64'(weff_r) - 64'd1;
          state_nxt = S_DD0;
        end
      end
      S_DD0: begin
        if (mul_done) begin
          t0_ld     = 1'b1;
          mul_ld    = 1'b1;
          mul_a_in  = {{64{su_r[63]}}, su_r};
          mul_b_in  = su_r;
          state_nxt = S_DD1;
        end
      end
      S_DD1: begin
        if (mul_done) begin
          dd_ld     = 1'b1;
          mul_ld    = 1'b1;
          mul_a_in  = suv_r;
          mul_b_in  = 64'(weff_r) - 64'd1;
          state_nxt = S_NN0;
        end
      end
      S_NN0: begin
        if (mul_done) begin
          t0_ld     = 1'b1;
          mul_ld    = 1'b1;
          mul_a_in  = {{64{su_r[63]}}, su_r};
          mul_b_in  = sv_r;
          state_nxt = S_NN1;
        end
      end
      S_NN1: begin
        if (mul_done) begin
          // flat residuals give rho 0
          if (dd_r != 128'd0 && !dd_r[127]) begin
            div_ld     = 1'b1;
            div_n_in   = diff;
            div_d_in   = dd_r;
            div_fb_in  = RHO_FB;
            div_lim_in = LIM_RHO;
            state_nxt  = S_RHO;
          end else begin
            res_ld    = 1'b1;
            res_st_in = ST_VALID;
            state_nxt = S_PUSH;
          end
        end
      end
      S_RHO: begin
        if (!dv_run_r) begin
          res_ld     = 1'b1;
          res_st_in  = ST_VALID;
          res_rho_in = dv_res_r[RHO_W-1:0];
          state_nxt  = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign push_go = (state_r == S_PUSH) && (!out_valid_q || out_ready);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      bars_r      <= '0;
      win_r       <= WIN_RESET;
      out_valid_q <= 1'b0;
      iss_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      mul_cnt_r   <= 4'd9;
      dv_run_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        wp_r   <= wp_inc;
        bars_r <= bars_inc;
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW) begin
        win_r <= pwdata[WIN_W-1:0];
      end
      if (push_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
      if (pass_go) begin
        iss_r <= '0;
      end else if (issuing) begin
        iss_r <= iss_r + 1'b1;
      end
      v1_r <= issuing;
      v2_r <= v1_r;
      v3_r <= v2_r && (state_r == S_RES);
      v4_r <= v3_r && !f3_r;
      if (mul_ld) begin
        mul_cnt_r <= '0;
      end else if (!mul_done) begin
        mul_cnt_r <= mul_cnt_r + 1'b1;
      end
      if (div_ld) begin
        dv_run_r <= 1'b1;
      end else if (dv_run_r && dv_fin) begin
        dv_run_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r <= start_addr;
      weff_r <= weff;
    end
    if (pass_go) begin
      addr_r <= pass_base;
      sx_r   <= '0;
      sy_r   <= '0;
      sxx_r  <= '0;
      sxy_r  <= '0;
      su_r   <= '0;
      sv_r   <= '0;
      suu_r  <= '0;
      suv_r  <= '0;
    end else begin
      if (issuing) begin
        addr_r <= (addr_r == AW'(MAX_WINDOW - 1)) ? '0 : addr_r + 1'b1;
      end
      if (v2_r && state_r == S_SUM) begin
        sx_r  <= sx_r + 64'(x2_r);
        sy_r  <= sy_r + 64'(y2_r);
        sxx_r <= sxx_r + 64'(m0_r);
        sxy_r <= sxy_r + 64'(m1_r);
      end
      if (v3_r && !f3_r) begin
        su_r <= su_r + {{16{prev_r[RES_W-1]}}, prev_r};
        sv_r <= sv_r + {{16{u3_r[RES_W-1]}}, u3_r};
      end
      if (v4_r) begin
        suu_r <= suu_r + aa_ext;
        suv_r <= suv_r + ba_ext;
      end
    end
    f1_r <= (iss_r == '0);
    f2_r <= f1_r;
    f3_r <= f2_r;
    if (v1_r) begin
      x2_r <= rd_open;
      y2_r <= rd_close;
      m0_r <= rd_open * op_a;
      m1_r <= rd_open * op_b;
    end
    if (v2_r) begin
      u3_r <= u_sat;
    end
    if (v3_r) begin
      prev_r  <= u3_r;
      aa_lo_r <= prev_r * $signed({1'b0, prev_r[23:0]});
      aa_hi_r <= prev_r * $signed(prev_r[47:24]);
      ba_lo_r <= u3_r * $signed({1'b0, prev_r[23:0]});
      ba_hi_r <= u3_r * $signed(prev_r[47:24]);
    end
    if (t0_ld) t0_r <= mul_acc_r;
    if (den_ld) den_r <= diff;
    if (dd_ld) dd_r <= diff;
    if (beta_ld) begin
      beta_neg_r <= dv_res_r[63];
      beta_mag_r <= dv_res_r[63] ? -dv_res_r[RES_W-1:0] : dv_res_r[RES_W-1:0];
    end
    if (alpha_ld) alpha_r <= dv_res_r[RES_W-1:0];
    if (res_ld) begin
      res_st_r  <= res_st_in;
      res_rho_r <= res_rho_in;
    end
    if (push_go) begin
      out_status_r <= res_st_r;
      out_rho_r    <= res_rho_r;
    end
    // multiplier: byte digits of b, then correct for a negative b
    if (mul_ld) begin
      mul_a_r   <= mul_a_in;
      mul_b_r   <= mul_b_in;
      mul_neg_r <= mul_b_in[63];
      mul_acc_r <= '0;
    end else if (mul_cnt_r < 4'd8) begin
      mul_acc_r <= mul_acc_r + (mul_pp << (8 * 0));
      mul_a_r   <= mul_a_r << 8;
      mul_b_r   <= mul_b_r >> 8;
    end else if (mul_cnt_r == 4'd8 && mul_neg_r) begin
      mul_acc_r <= mul_acc_r - mul_a_r;
    end
    // divider: integer bits first, then fraction plus one rounding bit
    if (div_ld) begin
      dv_r_r    <= '0;
      dv_n_r    <= dl_mag;
      dv_d_r    <= div_d_in;
      dv_q_r    <= '0;
      dv_ovf_r  <= 1'b0;
      dv_cnt_r  <= '0;
      dv_last_r <= 8'd128 + {2'b0, div_fb_in};
      dv_max_r  <= dl_max;
      dv_int_r  <= dl_max >> div_fb_in;
      dv_neg_r  <= dl_neg;
    end else if (dv_run_r) begin
      dv_r_r   <= dv_rnew;
      dv_n_r   <= dv_n_r << 1;
      dv_q_r   <= dv_qnew;
      dv_ovf_r <= dv_ovfnew;
      dv_cnt_r <= dv_cnt_r + 1'b1;
      if (dv_fin) begin
        dv_res_r <= dv_neg_r ? -$signed(dv_mag) : $signed(dv_mag);
      end
    end
  end

endmodule

[src/wrra_checker.sv]
// Port-level checker for the regression residual unit, bound to the top level.
module wrra_checker
  import wrra_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [STATUS_W-1:0]     out_status,
  input logic signed [RHO_W-1:0] out_rho,
  input logic                    psel,
  input logic                    penable,
  input logic                    pwrite,
  input logic [2:0]              paddr,
  input logic [31:0]             pwdata,
  input logic [31:0]             prdata,
  input logic                    pready
);

  // rho is only meaningful with a valid fit
  a_rho_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_VALID |-> out_rho == '0)
    else $error("rho nonzero without valid status");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_rho))
    else $error("stalled result changed");

  a_cfg_read: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && !paddr[2] ##1 psel && !paddr[2]
      |-> prdata[WIN_W-1:0] == $past(pwdata[WIN_W-1:0]))
    else $error("window register readback mismatch");

endmodule

bind window_regression_residual_ar1_unit wrra_checker u_wrra_checker (.*);

[tb/sv/window_regression_residual_ar1_unit_tb.sv]
// Self-checking testbench for the windowed regression residual AR(1) unit.
`timescale 1ns / 100ps

module window_regression_residual_ar1_unit_tb;
  import wrra_pkg::*;

  localparam int RING = 4096;
  localparam int LONG_HOLD = 3000;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [RHO_W-1:0]    rho;
  } fit_t;

  typedef struct {
    int                  win;    // negative: keep current window
    logic [PRICE_W-1:0]  open_p;
    logic [PRICE_W-1:0]  close_p;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [RHO_W-1:0]    rho;
  } bar_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PRICE_W-1:0] in_open_price = '0;
  logic [PRICE_W-1:0] in_close_price = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic signed [RHO_W-1:0] out_rho;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  window_regression_residual_ar1_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_open_price(in_open_price), .in_close_price(in_close_price),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_rho(out_rho),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [PRICE_W-1:0]    open_mem [RING];
  logic [PRICE_W-1:0]    close_mem [RING];
  logic signed [RES_W-1:0] resid_mem [RING];
  int unsigned wr_ptr = 0;
  int unsigned bars_in = 0;
  int unsigned win_len = WIN_RESET;

  fit_t fit_q[$];
  int errors = 0;
  bit hold_req = 1'b0;

  // sender shaping
  int burst_left = 0;
  longint slope_q4 = 4;
  longint base_open = 1000;
  longint last_open = 0;

  function automatic wide_t round_div(wide_t n, wide_t d, int fb, wide_t lim);
    wide_t mag, q, cap;
    mag = (n < 0) ? -n : n;
    q = (((mag <<< (fb + 1)) / d) + 1) >>> 1;
    cap = (n < 0) ? lim + 1 : lim;
    if (q > cap) q = cap;
    return (n < 0) ? -q : q;
  endfunction

  function automatic wide_t sat48(wide_t v);
    wide_t hi;
    hi = wide_t'(LIM48);
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // store the bar and compute the result it causes
  function automatic fit_t predict_fit(logic [PRICE_W-1:0] o, logic [PRICE_W-1:0] c);
    fit_t f;
    int unsigned w, start, j, k;
    wide_t ww, sx, sy, sxx, sxy, den, num, beta, alpha, an, t, x, y, a, b;
    wide_t su, sv, suu, suv, dd, nn, rho;
    open_mem[wr_ptr] = o;
    close_mem[wr_ptr] = c;
    wr_ptr = (wr_ptr + 1) % RING;
    if (bars_in < RING + HIST_EXTRA) bars_in++;
    w = win_len;
    if (w < WIN_MIN) w = WIN_MIN;
    if (w > RING) w = RING;
    f.status = ST_SHORT;
    f.rho = '0;
    if (bars_in < w + HIST_EXTRA) return f;
    ww = wide_t'(w);
    start = (wr_ptr + RING - w) % RING;
    sx = 0; sy = 0; sxx = 0; sxy = 0;
    for (k = 0; k < w; k++) begin
      j = (start + k) % RING;
      x = wide_t'(open_mem[j]);
      y = wide_t'(close_mem[j]);
      sx += x; sy += y; sxx += x * x; sxy += x * y;
    end
    den = ww * sxx - sx * sx;
    if (den == 0) begin
      f.status = ST_FLAT;
      return f;
    end
    num = ww * sxy - sx * sy;
    beta = round_div(num, den, BETA_FB, wide_t'(LIM48));
    an = (sy <<< 40) - beta * sx;
    alpha = round_div(an, ww <<< 24, ALPHA_FB, wide_t'(LIM48));
    for (k = 0; k < w; k++) begin
      j = (start + k) % RING;
      t = round_div(beta * wide_t'(open_mem[j]), wide_t'(1) <<< 24, 0, wide_t'(1) <<< 60);
      x = sat48((wide_t'(close_mem[j]) <<< 16) - alpha - t);
      resid_mem[k] = x[RES_W-1:0];
    end
    su = 0; sv = 0; suu = 0; suv = 0;
    for (k = 1; k < w; k++) begin
      a = wide_t'(resid_mem[k-1]);
      b = wide_t'(resid_mem[k]);
      su += a; sv += b; suu += a * a; suv += b * a;
    end
    dd = (ww - 1) * suu - su * su;
    nn = (ww - 1) * suv - su * sv;
    rho = 0;
    if (dd > 0) rho = round_div(nn, dd, RHO_FB, wide_t'(LIM_RHO));
    f.status = ST_VALID;
    f.rho = rho[RHO_W-1:0];
    return f;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // offer one bar, hold it until accepted, then maybe pause
  task automatic send_bar(bar_row_t row);
    fit_t f;
    int gap;
    in_valid <= 1'b1;
    in_open_price <= row.open_p;
    in_close_price <= row.close_p;
    do @(posedge clk); while (!in_ready);
    f = predict_fit(row.open_p, row.close_p);
    if (row.typed) begin
      f.status = row.status;
      f.rho = row.rho;
    end
    fit_q.push_back(f);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (fit_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(int unsigned v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_WINDOW, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    win_len = v & 32'h1FFF;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PRICE_W-1:0] clip24(longint v);
    if (v < 0) return '0;
    if (v > 64'hFFFFFF) return 24'hFFFFFF;
    return v[PRICE_W-1:0];
  endfunction

  // mostly near-linear bars, with flat runs, extremes and noise mixed in
  function automatic bar_row_t random_bar();
    bar_row_t r;
    int kind;
    longint o, spread;
    r.win = -1;
    r.typed = 1'b0;
    r.status = ST_SHORT;
    r.rho = '0;
    kind = $urandom_range(0, 99);
    spread = longint'(1) << $urandom_range(0, 20);
    if (kind < 60) begin
      o = base_open + $urandom_range(0, spread);
      r.open_p = clip24(o);
      r.close_p = clip24((longint'(r.open_p) * slope_q4) / 4 + 500
                         + $signed($urandom_range(0, 2 * spread)) - spread);
    end else if (kind < 70) begin
      r.open_p = clip24(last_open);
      r.close_p = PRICE_W'($urandom_range(0, 24'hFFFFFF));
    end else if (kind < 80) begin
      r.open_p = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
      r.close_p = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
    end else begin
      r.open_p = PRICE_W'($urandom_range(0, 24'hFFFFFF));
      r.close_p = PRICE_W'($urandom_range(0, 24'hFFFFFF));
    end
    last_open = r.open_p;
    return r;
  endfunction

  // receiver: random stall pattern, plus one long hold-off on request
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  int ready_pct = 100;
  int pat_cnt = 0;
  always @(posedge clk) begin
    fit_t e;
    if (out_valid && out_ready) begin
      if (fit_q.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        e = fit_q.pop_front();
        if (out_status !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, e.status));
        if (out_rho !== e.rho)
          report_mismatch($sformatf("rho %h, expected %h", out_rho, e.rho));
      end
    end
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      pat_cnt++;
      if (pat_cnt % 300 == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 70;
          2: ready_pct = 30;
          default: ready_pct = 90;
        endcase
      end
      out_ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  bar_row_t dir_rows [$];

  function automatic bar_row_t mk_row(int win, logic [23:0] o, logic [23:0] c,
                                      bit typed, logic [1:0] st);
    bar_row_t r;
    r.win = win;
    r.open_p = o;
    r.close_p = c;
    r.typed = typed;
    r.status = st;
    r.rho = '0;
    return r;
  endfunction

  int unsigned phase_win [13] = '{4, 5, 3, 7, 12, 31, 64, 200, 9, 16, 6, 4096, 3};
  int phase_cnt [13] = '{150, 150, 150, 120, 120, 100, 70, 45, 110, 90, 120, 40, 45};

  initial begin
    bar_row_t r;
    int p, n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes under the reset window: too little history
    dir_rows.push_back(mk_row(-1, 24'h000000, 24'h000000, 1, ST_SHORT));
    dir_rows.push_back(mk_row(-1, 24'hFFFFFF, 24'hFFFFFF, 1, ST_SHORT));
    dir_rows.push_back(mk_row(-1, 24'h000000, 24'hFFFFFF, 1, ST_SHORT));
    dir_rows.push_back(mk_row(-1, 24'hFFFFFF, 24'h000000, 1, ST_SHORT));
    // smallest window: fifth bar still short, sixth fits
    dir_rows.push_back(mk_row(3, 24'd100, 24'd200, 1, ST_SHORT));
    dir_rows.push_back(mk_row(-1, 24'd300, 24'd50, 0, ST_SHORT));
    // flat regressor once the window holds only one open price
    dir_rows.push_back(mk_row(-1, 24'd1000, 24'd0, 0, ST_SHORT));
    dir_rows.push_back(mk_row(-1, 24'd1000, 24'hFFFFFF, 0, ST_SHORT));
    dir_rows.push_back(mk_row(-1, 24'd1000, 24'd777, 1, ST_FLAT));
    dir_rows.push_back(mk_row(-1, 24'hFFFFFF, 24'd0, 0, ST_SHORT));
    // exact line: residuals all zero, so rho is zero
    dir_rows.push_back(mk_row(-1, 24'd10, 24'd25, 0, ST_SHORT));
    dir_rows.push_back(mk_row(-1, 24'd5000, 24'd10005, 0, ST_SHORT));
    dir_rows.push_back(mk_row(-1, 24'd123456, 24'd246917, 1, ST_VALID));
    // saturation corners
    dir_rows.push_back(mk_row(-1, 24'h000000, 24'hFFFFFF, 0, ST_SHORT));
    dir_rows.push_back(mk_row(-1, 24'hFFFFFF, 24'h000000, 0, ST_SHORT));
    dir_rows.push_back(mk_row(-1, 24'h000000, 24'hFFFFFF, 0, ST_SHORT));
    dir_rows.push_back(mk_row(-1, 24'hFFFFFF, 24'hFFFFFF, 0, ST_SHORT));
    dir_rows.push_back(mk_row(-1, 24'h000001, 24'h000000, 0, ST_SHORT));
    // window out of range on both sides: clamped
    dir_rows.push_back(mk_row(8191, 24'h000000, 24'h000000, 1, ST_SHORT));
    dir_rows.push_back(mk_row(0, 24'hFFFFFF, 24'hFFFFFF, 0, ST_SHORT));
    dir_rows.push_back(mk_row(2, 24'h123456, 24'h654321, 0, ST_SHORT));
    dir_rows.push_back(mk_row(1, 24'hABCDEF, 24'h0F0F0F, 0, ST_SHORT));
    dir_rows.push_back(mk_row(4096, 24'h5A5A5A, 24'hA5A5A5, 1, ST_SHORT));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].win >= 0) begin
        wait_idle();
        write_window(dir_rows[i].win);
      end
      send_bar(dir_rows[i]);
    end

    for (p = 0; p < 13; p++) begin
      wait_idle();
      write_window(phase_win[p]);
      slope_q4 = $urandom_range(0, 12);
      base_open = $urandom_range(0, 24'hF00000);
      if (p == 4) hold_req = 1'b1;
      for (n = 0; n < phase_cnt[p]; n++) begin
        if ($urandom_range(0, 49) == 0) begin
          slope_q4 = $urandom_range(0, 12);
          base_open = $urandom_range(0, 24'hF00000);
        end
        r = random_bar();
        send_bar(r);
      end
    end

    wait_idle();
    repeat (600) @(posedge clk);
    if (errors == 0 && fit_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[window_regression_residual_ar1_unit.f]
src/wrra_pkg.sv
src/wrra_ram.sv
src/window_regression_residual_ar1_unit.sv
src/wrra_checker.sv
tb/sv/window_regression_residual_ar1_unit_tb.sv
